FILE: hw/rtl/bpa_pkg.sv
// buddy page allocator package: sizes, status codes, datapath op codes
// and the command and status words between controller and datapath
// no dependencies
`default_nettype none
package bpa_pkg;

  localparam int BPA_MAX_ORDER  = 8;
  localparam int BPA_PAGE_SHIFT = 12;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_CLR     = 5'd1;
  localparam op_t OP_LOAD    = 5'd2;
  localparam op_t OP_INC     = 5'd3;
  localparam op_t OP_TAKE    = 5'd4;
  localparam op_t OP_URD     = 5'd5;
  localparam op_t OP_U1      = 5'd6;
  localparam op_t OP_U2      = 5'd7;
  localparam op_t OP_SDEC    = 5'd8;
  localparam op_t OP_S2      = 5'd9;
  localparam op_t OP_S3      = 5'd10;
  localparam op_t OP_AFIN    = 5'd11;
  localparam op_t OP_FRD     = 5'd12;
  localparam op_t OP_FCLR    = 5'd13;
  localparam op_t OP_MRD     = 5'd14;
  localparam op_t OP_M2      = 5'd15;
  localparam op_t OP_M3      = 5'd16;
  localparam op_t OP_P1      = 5'd17;
  localparam op_t OP_P2      = 5'd18;
  localparam op_t OP_ERR_BAD = 5'd19;
  localparam op_t OP_ERR_OOM = 5'd20;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic idx_bad;
    logic req_bad;
    logic head_nil;
    logic ord_max;
    logic ord_eq_req;
    logic meta_bad;
    logic bud_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bpa_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bpa_ctrl.sv
// controller state machine: sequences datapath ops for alloc and free
// depends on bpa_pkg
`default_nettype none
module bpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire bpa_pkg::stat_t st,
  output bpa_pkg::cmd_t       cmd,
  output logic                busy
);
  import bpa_pkg::*;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_SRCH = 5'd3;
  localparam logic [4:0] S_URD  = 5'd4;
  localparam logic [4:0] S_U1   = 5'd5;
  localparam logic [4:0] S_U2   = 5'd6;
  localparam logic [4:0] S_SCHK = 5'd7;
  localparam logic [4:0] S_S2   = 5'd8;
  localparam logic [4:0] S_S3   = 5'd9;
  localparam logic [4:0] S_FRD  = 5'd10;
  localparam logic [4:0] S_FCHK = 5'd11;
  localparam logic [4:0] S_MCHK = 5'd12;
  localparam logic [4:0] S_MTST = 5'd13;
  localparam logic [4:0] S_M2   = 5'd14;
  localparam logic [4:0] S_M3   = 5'd15;
  localparam logic [4:0] S_P1   = 5'd16;
  localparam logic [4:0] S_P2   = 5'd17;
  localparam logic [4:0] S_EBAD = 5'd18;
  localparam logic [4:0] S_EOOM = 5'd19;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.is_free) state_nxt = st.idx_bad ? S_EBAD : S_FRD;
        else            state_nxt = st.req_bad ? S_EBAD : S_SRCH;
      end
      S_SRCH: begin
        if (!st.head_nil) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_URD;
        end else if (st.ord_max) begin
          state_nxt = S_EOOM;
        end else begin
          cmd.op = OP_INC;
        end
      end
      S_URD: begin
        cmd.op    = OP_URD;
        state_nxt = S_U1;
      end
      S_U1: begin
        cmd.op    = OP_U1;
        state_nxt = S_U2;
      end
      S_U2: begin
        cmd.op    = OP_U2;
        state_nxt = st.is_free ? S_M2 : S_SCHK;
      end
      S_SCHK: begin
        if (st.ord_eq_req) begin
          cmd.op    = OP_AFIN;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SDEC;
          state_nxt = S_S2;
        end
      end
      S_S2: begin
        cmd.op    = OP_S2;
        state_nxt = S_S3;
      end
      S_S3: begin
        cmd.op    = OP_S3;
        state_nxt = S_SCHK;
      end
      S_FRD: begin
        cmd.op    = OP_FRD;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (st.meta_bad) begin
          state_nxt = S_EBAD;
        end else begin
          cmd.op    = OP_FCLR;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (st.ord_max) begin
          state_nxt = S_P1;
        end else begin
          cmd.op    = OP_MRD;
          state_nxt = S_MTST;
        end
      end
      S_MTST: state_nxt = st.bud_free ? S_URD : S_P1;
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_MCHK;
      end
      S_P1: begin
        cmd.op    = OP_P1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.op    = OP_P2;
        state_nxt = S_IDLE;
      end
      S_EBAD: begin
        cmd.op    = OP_ERR_BAD;
        state_nxt = S_IDLE;
      end
      S_EOOM: begin
        cmd.op    = OP_ERR_OOM;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bpa_dp.sv
// datapath: page tag and link memories, list head and tail registers,
// working registers and the result word; depends on bpa_pkg and bpa_ram
`default_nettype none
module bpa_dp #(
  parameter int MAX_ORDER  = bpa_pkg::BPA_MAX_ORDER,
  parameter int PAGE_SHIFT = bpa_pkg::BPA_PAGE_SHIFT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bpa_pkg::cmd_t cmd,
  output bpa_pkg::stat_t     st,
  input  wire logic          in_kind,
  input  wire logic [3:0]    in_request_order,
  input  wire logic [7:0]    in_page_index,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [39:0]   cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [7:0]         out_block_page,
  output logic [3:0]         out_block_order,
  output logic [40:0]        out_block_address
);
  import bpa_pkg::*;

  localparam int PAGES = 1 << MAX_ORDER;
  localparam int PW    = MAX_ORDER;
  localparam int LW    = MAX_ORDER + 1;
  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int MW    = OW + 1;
  localparam logic [LW-1:0] NIL    = LW'(PAGES);
  localparam logic [OW-1:0] NO_ORD = OW'(MAX_ORDER + 1);
  localparam logic [OW-1:0] TOP    = OW'(MAX_ORDER);

  logic          kind_r;
  logic [3:0]    req_r;
  logic          idx_bad_r;
  logic [PW-1:0] idx_r, blk_r, tgt_r, bud_r, clr_cnt_r;
  logic [OW-1:0] ord_r;
  logic [39:0]   base_r;
  logic [LW-1:0] head_r [MAX_ORDER+1];
  logic [LW-1:0] tail_r [MAX_ORDER+1];

  logic          meta_we, link_re, meta_re, nxt_we, prv_we;
  logic [PW-1:0] meta_wa, meta_ra, nxt_wa, prv_wa;
  logic [MW-1:0] meta_wd, meta_rd;
  logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

  logic [LW-1:0] head_c, tail_c;
  logic [PW-1:0] bud_c, half_c, lo_c, hi_c;
  logic [OW-1:0] rd_tag;
  logic          rd_used;

  assign head_c  = head_r[ord_r];
  assign tail_c  = tail_r[ord_r];
  assign bud_c   = idx_r ^ (PW'(1) << ord_r);
  assign half_c  = blk_r + (PW'(1) << ord_r);
  assign lo_c    = (bud_r < idx_r) ? bud_r : idx_r;
  assign hi_c    = (bud_r < idx_r) ? idx_r : bud_r;
  assign rd_tag  = meta_rd[MW-1:1];
  assign rd_used = meta_rd[0];

  assign cfg_ready = 1'b1;

  always_comb begin
    st.clr_last   = &clr_cnt_r;
    st.is_free    = kind_r;
    st.idx_bad    = idx_bad_r;
    st.req_bad    = int'(req_r) > MAX_ORDER;
    st.head_nil   = (head_c == NIL);
    st.ord_max    = (ord_r == TOP);
    st.ord_eq_req = int'(ord_r) == int'(req_r);
    st.meta_bad   = !rd_used || (rd_tag > TOP);
    st.bud_free   = !rd_used && (rd_tag == ord_r);
  end

  // memory ports for each op
  always_comb begin
    meta_we = 1'b0;
    meta_wa = idx_r;
    meta_wd = {NO_ORD, 1'b0};
    meta_re = (cmd.op == OP_FRD) || (cmd.op == OP_MRD);
    meta_ra = (cmd.op == OP_FRD) ? idx_r : bud_c;
    link_re = (cmd.op == OP_URD);
    nxt_we  = 1'b0;
    nxt_wa  = tgt_r;
    nxt_wd  = NIL;
    prv_we  = 1'b0;
    prv_wa  = tgt_r;
    prv_wd  = NIL;
    case (cmd.op)
      OP_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_cnt_r;
        meta_wd = {(clr_cnt_r == '0) ? TOP : NO_ORD, 1'b0};
        nxt_we  = 1'b1;
        nxt_wa  = clr_cnt_r;
        prv_we  = 1'b1;
        prv_wa  = clr_cnt_r;
      end
      OP_U1: begin
        nxt_we = (prv_rd != NIL);
        nxt_wa = prv_rd[PW-1:0];
        nxt_wd = nxt_rd;
        prv_we = (nxt_rd != NIL);
        prv_wa = nxt_rd[PW-1:0];
        prv_wd = prv_rd;
      end
      OP_U2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      OP_S2: begin
        meta_we = 1'b1;
        meta_wa = half_c;
        meta_wd = {ord_r, 1'b0};
        prv_we  = 1'b1;
        prv_wa  = half_c;
        prv_wd  = tail_c;
        nxt_we  = 1'b1;
        nxt_wa  = half_c;
      end
      OP_S3: begin
        nxt_we = (tail_c != NIL);
        nxt_wa = tail_c[PW-1:0];
        nxt_wd = {1'b0, half_c};
      end
      OP_AFIN: begin
        meta_we = 1'b1;
        meta_wa = blk_r;
        meta_wd = {OW'(req_r), 1'b1};
      end
      OP_FCLR: begin
        meta_we = 1'b1;
        meta_wd = {rd_tag, 1'b0};
      end
      OP_M2: begin
        meta_we = 1'b1;
        meta_wa = hi_c;
      end
      OP_M3: begin
        meta_we = 1'b1;
        meta_wa = lo_c;
        meta_wd = {ord_r + OW'(1), 1'b0};
      end
      OP_P1: begin
        prv_we = 1'b1;
        prv_wa = idx_r;
        nxt_we = 1'b1;
        nxt_wa = idx_r;
        nxt_wd = head_c;
      end
      OP_P2: begin
        prv_we = (head_c != NIL);
        prv_wa = head_c[PW-1:0];
        prv_wd = {1'b0, idx_r};
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(.W(MW), .D(PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .re(meta_re), .raddr(meta_ra), .rdata(meta_rd)
  );

  bpa_ram #(.W(LW), .D(PAGES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .re(link_re), .raddr(tgt_r), .rdata(nxt_rd)
  );

  bpa_ram #(.W(LW), .D(PAGES)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .re(link_re), .raddr(tgt_r), .rdata(prv_rd)
  );

  // list heads and tails, base register, clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_r[i] <= (i == MAX_ORDER) ? '0 : NIL;
        tail_r[i] <= (i == MAX_ORDER) ? '0 : NIL;
      end
      base_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
      case (cmd.op)
        OP_CLR: clr_cnt_r <= clr_cnt_r + PW'(1);
        OP_U1: begin
          if (prv_rd == NIL) head_r[ord_r] <= nxt_rd;
          if (nxt_rd == NIL) tail_r[ord_r] <= prv_rd;
        end
        OP_S3: begin
          if (tail_c == NIL) head_r[ord_r] <= {1'b0, half_c};
          tail_r[ord_r] <= {1'b0, half_c};
        end
        OP_P2: begin
          if (head_c == NIL) tail_r[ord_r] <= {1'b0, idx_r};
          head_r[ord_r] <= {1'b0, idx_r};
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r    <= in_kind;
        req_r     <= in_request_order;
        idx_r     <= PW'(in_page_index);
        idx_bad_r <= int'(in_page_index) >= PAGES;
        ord_r     <= OW'(in_request_order);
      end
      OP_INC:  ord_r <= ord_r + OW'(1);
      OP_SDEC: ord_r <= ord_r - OW'(1);
      OP_TAKE: begin
        blk_r <= head_c[PW-1:0];
        tgt_r <= head_c[PW-1:0];
      end
      OP_FCLR: ord_r <= rd_tag;
      OP_MRD: begin
        bud_r <= bud_c;
        tgt_r <= bud_c;
      end
      OP_M3: begin
        idx_r <= lo_c;
        ord_r <= ord_r + OW'(1);
      end
      default: begin
      end
    endcase
  end

  // result word
  logic          res_ok;
  logic [PW-1:0] res_page;
  logic [OW-1:0] res_ord;

  assign res_ok   = (cmd.op == OP_AFIN) || (cmd.op == OP_P2);
  assign res_page = (cmd.op == OP_AFIN) ? blk_r : idx_r;
  assign res_ord  = (cmd.op == OP_AFIN) ? OW'(req_r) : ord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_ok || (cmd.op == OP_ERR_BAD) || (cmd.op == OP_ERR_OOM);
    end
  end

  always_ff @(posedge clk) begin
    if (res_ok) begin
      out_status        <= ST_OK;
      out_block_page    <= 8'(res_page);
      out_block_order   <= 4'(res_ord);
      out_block_address <= 41'(base_r) + (41'(res_page) << PAGE_SHIFT);
    end else begin
      out_status        <= (cmd.op == OP_ERR_OOM) ? ST_OOM : ST_BAD;
      out_block_page    <= '0;
      out_block_order   <= '0;
      out_block_address <= '0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/buddy_page_allocator.sv
// buddy page allocator top level: controller plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_dp (and bpa_ram below it)
//
//  channel   ports                                      handshake
//  request   in_kind, in_request_order, in_page_index   start & !busy
//  result    out_status, out_block_*                    out_valid, one cycle
//  config    cfg_data (pool base)                       cfg_valid & cfg_ready
//
// after reset the page memories are swept, every page in turn, with busy
// high; the config port is always ready
// alloc searches up one order at a time from the request order until a
// list is found, unlinks its head, then splits down to the request order
// free merges with free buddies until it reaches the top order or a used
// buddy stops it, then pushes the block; bad order, bad free and out of
// memory end in an error result; the tag and link memories each take one
// read and one write per cycle; one word is in flight at a time
// out_valid is high in the first cycle with busy low; the receiver cannot stall
`default_nettype none
module buddy_page_allocator #(
  parameter int MAX_ORDER  = bpa_pkg::BPA_MAX_ORDER,
  parameter int PAGE_SHIFT = bpa_pkg::BPA_PAGE_SHIFT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [3:0]  in_request_order,
  input  wire logic [7:0]  in_page_index,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_block_page,
  output logic [3:0]       out_block_order,
  output logic [40:0]      out_block_address,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [39:0] cfg_data
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  // memories, list pointers and result word
  bpa_dp #(.MAX_ORDER(MAX_ORDER), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_kind(in_kind), .in_request_order(in_request_order),
    .in_page_index(in_page_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status),
    .out_block_page(out_block_page), .out_block_order(out_block_order),
    .out_block_address(out_block_address)
  );

`ifndef SYNTHESIS
  // a result only closes a word that was being worked on
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // failed requests carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_block_page == 8'd0 && out_block_order == 4'd0 &&
       out_block_address == 41'd0))
    else $error("error result with nonzero fields");

  // only the three status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OOM ||
                   out_status == ST_BAD))
    else $error("bad status code");
`endif
endmodule
`default_nettype wire
